@@ rtl/olids_pkg.sv @@
package olids_pkg;

  typedef logic signed [31:0] olids_value_t;

  typedef enum logic [1:0] {
    CMD_INS_FRONT,
    CMD_INS_REAR,
    CMD_DELETE,
    CMD_SEARCH
  } olids_cmd_t;

  typedef enum logic [2:0] {
    STATUS_OK,
    STATUS_EMPTY,
    STATUS_BAD_POS,
    STATUS_NOT_FOUND,
    STATUS_FULL
  } olids_status_t;

endpackage

@@ rtl/olids_ram.sv @@
module olids_ram #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  olids_pkg::olids_value_t      wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output olids_pkg::olids_value_t      rdata
);
  import olids_pkg::*;

  olids_value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ordered_list_insert_delete_search_unit.sv @@
// Bounded ordered list of signed 32-bit values, held as a ring in one
// simple dual-port RAM of DEPTH words (one write and one registered read a
// cycle) with a head pointer and an occupancy count. One request is worked
// on at a time: insert at front or rear writes the value in the execute
// state (head moves back for a front insert, so nothing shifts); delete at
// position p makes one RAM read and one write-back a cycle as the tail
// slides down by one; search makes one RAM read a cycle, with the compare
// on the registered read data in the cycle after each read. Empty, full and
// bad-position requests go straight from execution to completion. The
// engine returns to idle at the same edge that loads the result. The
// result sits in an output register, so a new request is taken as soon as
// the engine is idle even if the previous result has not been taken yet.
// found_position and entry_count are reported in 5 bits and wrap for DEPTH
// above 31. The RAM needs no clearing after reset: only entries below the
// count are ever read.
module ordered_list_insert_delete_search_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // value[31:0], position[37:32], zero pad
  input  logic [1:0]  s_tuser,   // command[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // found_position[4:0], entry_count[9:5], zero pad
  output logic [2:0]  m_tuser    // status[2:0]
);
  import olids_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_DELETE,
    ST_DONE
  } state_t;

  // ring index arithmetic, a below DEPTH and b at most DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [OW-1:0] b);
    logic [OW:0] s;
    s = (OW+1)'(a) + (OW+1)'(b);
    if (s >= (OW+1)'(DEPTH)) begin
      s = s - (OW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  state_t        state;
  logic [AW-1:0] head;
  logic [OW-1:0] occ;
  olids_cmd_t    cmd;
  olids_value_t  key;
  logic [5:0]    pos;
  logic [OW-1:0] issue_k;     // logical index of next RAM read
  logic [AW-1:0] cmp_k;       // logical index of data being compared
  logic [AW-1:0] rptr;
  logic [AW-1:0] wptr;
  logic          rd_vld;
  olids_status_t res_status;
  logic [4:0]    res_found;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  olids_value_t  mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  olids_value_t  mem_rdata;

  logic [AW-1:0] head_dec;
  logic          is_full;
  logic          bad_pos;

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign is_full  = (occ == OW'(DEPTH));
  assign bad_pos  = (pos == 6'd0) || (32'(pos) > 32'(occ));
  assign s_tready = (state == ST_IDLE);

  olids_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // ram port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = rptr;
    case (state)
      ST_EXEC: begin
        if ((cmd == CMD_INS_FRONT || cmd == CMD_INS_REAR) && !is_full) begin
          mem_we    = 1'b1;
          mem_waddr = (cmd == CMD_INS_FRONT) ? head_dec : wrap_add(head, occ);
          mem_wdata = key;
        end
      end
      ST_SEARCH: begin
        mem_re = (issue_k < occ);
      end
      ST_DELETE: begin
        // read one ahead, write the previous word one slot lower
        mem_re = (issue_k < occ);
        mem_we = rd_vld;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      occ      <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= mem_re;
      // the completion state reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd   <= olids_cmd_t'(s_tuser);
            key   <= s_tdata[31:0];
            pos   <= s_tdata[37:32];
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_found <= '0;
          case (cmd)
            CMD_INS_FRONT, CMD_INS_REAR: begin
              if (is_full) begin
                res_status <= STATUS_FULL;
              end else begin
                res_status <= STATUS_OK;
                occ        <= occ + 1'b1;
                if (cmd == CMD_INS_FRONT) begin
                  head <= head_dec;
                end
              end
              state <= ST_DONE;
            end
            CMD_DELETE: begin
              if (occ == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= ST_DONE;
              end else if (bad_pos) begin
                res_status <= STATUS_BAD_POS;
                state      <= ST_DONE;
              end else begin
                issue_k <= OW'(pos);
                rptr    <= wrap_add(head, OW'(pos));
                wptr    <= wrap_add(head, OW'(pos) - OW'(1));
                state   <= ST_DELETE;
              end
            end
            default: begin
              if (occ == '0) begin
                res_status <= STATUS_EMPTY;
                state      <= ST_DONE;
              end else begin
                issue_k <= '0;
                cmp_k   <= '0;
                rptr    <= head;
                state   <= ST_SEARCH;
              end
            end
          endcase
        end
        ST_SEARCH: begin
          if (mem_re) begin
            rptr    <= wrap_inc(rptr);
            issue_k <= issue_k + 1'b1;
          end
          if (rd_vld) begin
            if (mem_rdata == key) begin
              res_status <= STATUS_OK;
              res_found  <= 5'(OW'(cmp_k) + OW'(1));
              state      <= ST_DONE;
            end else if (OW'(cmp_k) + OW'(1) == occ) begin
              res_status <= STATUS_NOT_FOUND;
              state      <= ST_DONE;
            end else begin
              cmp_k <= cmp_k + 1'b1;
            end
          end
        end
        ST_DELETE: begin
          if (mem_re) begin
            rptr    <= wrap_inc(rptr);
            issue_k <= issue_k + 1'b1;
          end
          if (rd_vld) begin
            wptr <= wrap_inc(wptr);
          end
          if (!mem_re && !rd_vld) begin
            occ        <= occ - 1'b1;
            res_status <= STATUS_OK;
            state      <= ST_DONE;
          end
        end
        ST_DONE: begin
          // wait for the output register to free up
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {6'b0, 5'(occ), res_found};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // occupancy never runs past the store size
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= DEPTH)
    else $error("occupancy above depth");

  // an accepted request blocks further requests until its result is queued
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // a new result only comes from the completion state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result loaded outside completion");

  // ram reads and writes never happen while idle
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !mem_we && !mem_re)
    else $error("ram access while idle");

endmodule
